// File: rtl/hbrp_pkg.sv
// Shared types, character codes and helpers for the HTTP byte-range parser.
`timescale 1ns / 1ps

package hbrp_pkg;

    // Width of byte offsets and of the file size.
    localparam int NUM_W = 63;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Command codes of an input request.
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Character codes used by the parser.
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CASE_OFS = 8'h20;

    // Index of the last character of the unit prefix.
    localparam logic [2:0] PREFIX_LAST = 3'd5;

    // Parse phase of the front.
    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // Result codes.
    typedef enum logic [1:0] {
        OUT_NONE  = 2'd0,
        OUT_OK    = 2'd1,
        OUT_UNSAT = 2'd2,
        OUT_BAD   = 2'd3
    } t_outcome;

    // Parse summary handed from the front to the back at each end request.
    typedef struct packed {
        logic              any_seen;
        logic              shape_bad;
        logic              first_present;
        logic              first_bad;
        logic [NUM_W-1:0]  first_num;
        logic              second_present;
        logic              second_bad;
        logic [NUM_W-1:0]  second_num;
    } t_snap;

    // Lower-case text of the unit prefix, one character per index.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h79;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h73;
            3'd5:    ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/hbrp_front.sv
// Front of the parser: takes header characters and builds the parse summary.
`timescale 1ns / 1ps

module hbrp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_command,
    input  logic [7:0]           i_char_code,
    input  logic                 i_full,
    output logic                 o_push,
    output hbrp_pkg::t_snap      o_snap
);

    localparam int PROD_W = hbrp_pkg::NUM_W + 5;

    hbrp_pkg::t_phase          r_phase, n_phase;
    logic [2:0]                r_prefix_idx, n_prefix_idx;
    logic                      r_any_seen, n_any_seen;
    logic [hbrp_pkg::NUM_W-1:0] r_first_num, n_first_num;
    logic                      r_first_present, n_first_present;
    logic                      r_first_bad, n_first_bad;
    logic [hbrp_pkg::NUM_W-1:0] r_second_num, n_second_num;
    logic                      r_second_present, n_second_present;
    logic                      r_second_bad, n_second_bad;
    logic                      r_trailing, n_trailing;
    logic                      r_malformed, n_malformed;

    logic                      accept;
    logic                      is_end;
    logic [7:0]                lower_ch;
    logic                      prefix_match;
    logic                      is_blank;
    logic                      is_digit;
    logic [3:0]                digit;
    logic                      use_second;
    logic [hbrp_pkg::NUM_W-1:0] acc_num;
    logic                      acc_present;
    logic                      acc_bad;
    logic [PROD_W-1:0]         acc_ext;
    logic [PROD_W-1:0]         acc_prod;
    logic                      acc_ovf;
    logic [hbrp_pkg::NUM_W-1:0] feed_num;
    logic                      feed_present;
    logic                      feed_bad;
    logic                      feed_trailing;

    // Only end requests need queue space, but the stall is kept simple.
    assign o_stall = i_full;
    assign accept  = i_valid && !o_stall;
    assign is_end  = (i_command == hbrp_pkg::CMD_END);
    assign o_push  = accept && is_end;

    // Summary of the parse as it stands when the end request arrives.
    always_comb begin
        o_snap.any_seen       = r_any_seen;
        o_snap.shape_bad      = r_malformed || (r_phase == hbrp_pkg::PH_PREFIX)
                                || (r_phase == hbrp_pkg::PH_FIRST);
        o_snap.first_present  = r_first_present;
        o_snap.first_bad      = r_first_bad;
        o_snap.first_num      = r_first_num;
        o_snap.second_present = r_second_present;
        o_snap.second_bad     = r_second_bad;
        o_snap.second_num     = r_second_num;
    end

    // Character classification.
    assign lower_ch = ((i_char_code >= hbrp_pkg::CH_UPPER_A) &&
                       (i_char_code <= hbrp_pkg::CH_UPPER_Z)) ?
                      (i_char_code + hbrp_pkg::CH_CASE_OFS) : i_char_code;
    assign prefix_match = (lower_ch == hbrp_pkg::prefix_char(r_prefix_idx));
    assign is_blank = (i_char_code == hbrp_pkg::CH_SPACE) ||
                      (i_char_code == hbrp_pkg::CH_TAB);
    assign is_digit = (i_char_code >= hbrp_pkg::CH_ZERO) &&
                      (i_char_code <= hbrp_pkg::CH_NINE);
    assign digit    = 4'(i_char_code - hbrp_pkg::CH_ZERO);

    // One shared decimal accumulator serves whichever part is being parsed.
    assign use_second  = (r_phase == hbrp_pkg::PH_SECOND);
    assign acc_num     = use_second ? r_second_num : r_first_num;
    assign acc_present = use_second ? r_second_present : r_first_present;
    assign acc_bad     = use_second ? r_second_bad : r_first_bad;
    assign acc_ext     = PROD_W'(acc_num);
    assign acc_prod    = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(digit);
    assign acc_ovf     = (acc_prod[PROD_W-1:hbrp_pkg::NUM_W] != '0);

    // Effect of one character on the current number part.
    always_comb begin
        feed_num      = acc_num;
        feed_present  = acc_present;
        feed_bad      = acc_bad;
        feed_trailing = r_trailing;
        if (is_blank) begin
            if (acc_present) begin
                feed_trailing = 1'b1;
            end
        end else begin
            feed_present = 1'b1;
            if (!is_digit || r_trailing) begin
                feed_bad = 1'b1;
            end else if (!acc_bad) begin
                if (acc_ovf) begin
                    feed_bad = 1'b1;
                end else begin
                    feed_num = acc_prod[hbrp_pkg::NUM_W-1:0];
                end
            end
        end
    end

    // Next parse phase.
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            if (is_end) begin
                n_phase = hbrp_pkg::PH_PREFIX;
            end else if (!r_malformed) begin
                unique case (r_phase)
                    hbrp_pkg::PH_PREFIX: begin
                        if (prefix_match && (r_prefix_idx == hbrp_pkg::PREFIX_LAST)) begin
                            n_phase = hbrp_pkg::PH_FIRST;
                        end
                    end
                    hbrp_pkg::PH_FIRST: begin
                        if (i_char_code == hbrp_pkg::CH_DASH) begin
                            n_phase = hbrp_pkg::PH_SECOND;
                        end
                    end
                    hbrp_pkg::PH_SECOND: begin
                        if (i_char_code == hbrp_pkg::CH_COMMA) begin
                            n_phase = hbrp_pkg::PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // Next values of the parse registers.
    always_comb begin
        n_prefix_idx     = r_prefix_idx;
        n_any_seen       = r_any_seen;
        n_first_num      = r_first_num;
        n_first_present  = r_first_present;
        n_first_bad      = r_first_bad;
        n_second_num     = r_second_num;
        n_second_present = r_second_present;
        n_second_bad     = r_second_bad;
        n_trailing       = r_trailing;
        n_malformed      = r_malformed;
        if (accept) begin
            if (is_end) begin
                n_prefix_idx     = '0;
                n_any_seen       = 1'b0;
                n_first_num      = '0;
                n_first_present  = 1'b0;
                n_first_bad      = 1'b0;
                n_second_num     = '0;
                n_second_present = 1'b0;
                n_second_bad     = 1'b0;
                n_trailing       = 1'b0;
                n_malformed      = 1'b0;
            end else begin
                n_any_seen = 1'b1;
                if (!r_malformed) begin
                    unique case (r_phase)
                        hbrp_pkg::PH_PREFIX: begin
                            if (prefix_match) begin
                                n_prefix_idx = r_prefix_idx + 3'd1;
                            end else begin
                                n_malformed = 1'b1;
                            end
                        end
                        hbrp_pkg::PH_FIRST: begin
                            if (i_char_code == hbrp_pkg::CH_DASH) begin
                                n_trailing = 1'b0;
                            end else if (i_char_code == hbrp_pkg::CH_COMMA) begin
                                n_malformed = 1'b1;
                            end else begin
                                n_first_num     = feed_num;
                                n_first_present = feed_present;
                                n_first_bad     = feed_bad;
                                n_trailing      = feed_trailing;
                            end
                        end
                        hbrp_pkg::PH_SECOND: begin
                            if (i_char_code != hbrp_pkg::CH_COMMA) begin
                                n_second_num     = feed_num;
                                n_second_present = feed_present;
                                n_second_bad     = feed_bad;
                                n_trailing       = feed_trailing;
                            end
                        end
                        default: begin
                            n_trailing = r_trailing;
                        end
                    endcase
                end
            end
        end
    end

    // Parse registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= hbrp_pkg::PH_PREFIX;
            r_prefix_idx     <= '0;
            r_any_seen       <= 1'b0;
            r_first_num      <= '0;
            r_first_present  <= 1'b0;
            r_first_bad      <= 1'b0;
            r_second_num     <= '0;
            r_second_present <= 1'b0;
            r_second_bad     <= 1'b0;
            r_trailing       <= 1'b0;
            r_malformed      <= 1'b0;
        end else begin
            r_phase          <= n_phase;
            r_prefix_idx     <= n_prefix_idx;
            r_any_seen       <= n_any_seen;
            r_first_num      <= n_first_num;
            r_first_present  <= n_first_present;
            r_first_bad      <= n_first_bad;
            r_second_num     <= n_second_num;
            r_second_present <= n_second_present;
            r_second_bad     <= n_second_bad;
            r_trailing       <= n_trailing;
            r_malformed      <= n_malformed;
        end
    end

    // The prefix index only counts while the prefix is being matched.
    a_prefix_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hbrp_pkg::PH_PREFIX) |-> (r_prefix_idx <= hbrp_pkg::PREFIX_LAST))
        else $error("prefix index past the end of the prefix");

    // An end request is never handed over while the queue is full.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("summary pushed into a full queue");

endmodule

// File: rtl/hbrp_queue.sv
// Short queue of parse summaries between the front and the back.
`timescale 1ns / 1ps

module hbrp_queue #(
    parameter int DEPTH = hbrp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hbrp_pkg::t_snap i_data,
    output logic            o_full,
    output logic            o_valid,
    output hbrp_pkg::t_snap o_data,
    input  logic            i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hbrp_pkg::t_snap   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue fill count beyond its depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

// File: rtl/hbrp_back.sv
// Back of the parser: checks the summary against the file size and reports.
`timescale 1ns / 1ps

module hbrp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hbrp_pkg::NUM_W-1:0]  i_cfg_wdata,
    input  logic                        i_q_valid,
    input  hbrp_pkg::t_snap             i_q_data,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_outcome,
    output logic [hbrp_pkg::NUM_W-1:0]  o_range_start,
    output logic signed [hbrp_pkg::NUM_W:0] o_range_end
);

    localparam int NUM_W = hbrp_pkg::NUM_W;

    logic [NUM_W-1:0]        r_file_size;

    // First stage: classification and clamping.
    logic                    r_v1;
    hbrp_pkg::t_outcome      r_s1_outcome, n_s1_outcome;
    logic                    r_s1_cmp, n_s1_cmp;
    logic [NUM_W-1:0]        r_s1_start, n_s1_start;
    logic [NUM_W:0]          r_s1_end, n_s1_end;

    // Second stage: output register.
    logic                    r_v2;
    hbrp_pkg::t_outcome      r_out_outcome;
    logic [NUM_W-1:0]        r_out_start;
    logic [NUM_W:0]          r_out_end;

    logic                    adv2;
    logic                    load1;
    logic [NUM_W:0]          fs_m1;
    logic                    first_ge;
    logic                    second_ge;
    logic [NUM_W-1:0]        sfx_start;
    logic [NUM_W:0]          to_end;
    logic                    end_below;

    // File size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= '0;
        end else if (i_cfg_we) begin
            r_file_size <= i_cfg_wdata;
        end
    end

    // Pipeline flow.
    assign adv2    = !r_v2 || !i_stall;
    assign load1   = !r_v1 || adv2;
    assign o_q_pop = i_q_valid && load1;

    // Parallel compares against the file size.
    assign fs_m1     = {1'b0, r_file_size} - (NUM_W + 1)'(1);
    assign first_ge  = (i_q_data.first_num >= r_file_size);
    assign second_ge = (i_q_data.second_num >= r_file_size);
    assign sfx_start = second_ge ? '0 : (r_file_size - i_q_data.second_num);
    assign to_end    = (i_q_data.second_present && !second_ge) ?
                       {1'b0, i_q_data.second_num} : fs_m1;

    // Classification of one summary; the end-below-start check waits a stage.
    always_comb begin
        n_s1_outcome = hbrp_pkg::OUT_BAD;
        n_s1_cmp     = 1'b0;
        n_s1_start   = '0;
        n_s1_end     = '0;
        priority if (!i_q_data.any_seen) begin
            n_s1_outcome = hbrp_pkg::OUT_NONE;
        end else if (i_q_data.shape_bad) begin
            n_s1_outcome = hbrp_pkg::OUT_BAD;
        end else if (!i_q_data.first_present && !i_q_data.second_present) begin
            n_s1_outcome = hbrp_pkg::OUT_BAD;
        end else if (!i_q_data.first_present) begin
            // Suffix form.
            if (i_q_data.second_bad) begin
                n_s1_outcome = hbrp_pkg::OUT_BAD;
            end else if (i_q_data.second_num == '0) begin
                n_s1_outcome = hbrp_pkg::OUT_UNSAT;
            end else begin
                n_s1_outcome = hbrp_pkg::OUT_OK;
                n_s1_start   = sfx_start;
                n_s1_end     = fs_m1;
            end
        end else if (i_q_data.first_bad) begin
            n_s1_outcome = hbrp_pkg::OUT_BAD;
        end else if (first_ge) begin
            n_s1_outcome = hbrp_pkg::OUT_UNSAT;
        end else if (i_q_data.second_present && i_q_data.second_bad) begin
            n_s1_outcome = hbrp_pkg::OUT_BAD;
        end else begin
            n_s1_outcome = hbrp_pkg::OUT_OK;
            n_s1_cmp     = 1'b1;
            n_s1_start   = i_q_data.first_num;
            n_s1_end     = to_end;
        end
    end

    // First stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (load1) begin
            r_v1 <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_s1_outcome <= n_s1_outcome;
            r_s1_cmp     <= n_s1_cmp;
            r_s1_start   <= n_s1_start;
            r_s1_end     <= n_s1_end;
        end
    end

    // In the general form the end here is below the file size, so its top bit is clear.
    assign end_below = r_s1_cmp && (r_s1_end[NUM_W-1:0] < r_s1_start);

    // Output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            if (end_below) begin
                r_out_outcome <= hbrp_pkg::OUT_UNSAT;
                r_out_start   <= '0;
                r_out_end     <= '0;
            end else begin
                r_out_outcome <= r_s1_outcome;
                r_out_start   <= r_s1_start;
                r_out_end     <= r_s1_end;
            end
        end
    end

    assign o_valid       = r_v2;
    assign o_outcome     = r_out_outcome;
    assign o_range_start = r_out_start;
    assign o_range_end   = r_out_end;

    // Only an ok result carries offsets.
    a_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && (r_out_outcome != hbrp_pkg::OUT_OK)) |->
        ((r_out_start == '0) && (r_out_end == '0)))
        else $error("offsets set on a result that is not ok");

    // A request in the first stage is not lost while the output waits.
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && i_stall) |=> r_v1)
        else $error("first stage dropped a request during a stall");

endmodule

// File: rtl/http_byte_range_parser_top.sv
// Top level of the HTTP byte-range header parser.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    i_command, i_char_code
//  result    out        o_valid / i_stall    o_outcome, o_range_start, o_range_end
//  config    in         i_cfg_we             i_cfg_wdata (file size)
//
//  One request is taken per cycle while o_stall is low; a character request gives no result.
//  An end request gives its result through the summary queue, the classification stage
//  and the output register, in that order.
//  Reset is synchronous and active low and sets the file size to zero.
//  The input stalls only while the summary queue is full, which happens when
//  end requests pile up behind a stalled result.

module http_byte_range_parser_top #(
    parameter int QUEUE_DEPTH = hbrp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hbrp_pkg::NUM_W-1:0]      i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_command,
    input  logic [7:0]                      i_char_code,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_outcome,
    output logic [hbrp_pkg::NUM_W-1:0]      o_range_start,
    output logic signed [hbrp_pkg::NUM_W:0] o_range_end
);

    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    hbrp_pkg::t_snap push_snap;
    hbrp_pkg::t_snap q_snap;

    // Character parsing.
    hbrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .i_full      (q_full),
        .o_push      (push),
        .o_snap      (push_snap)
    );

    // Summaries waiting for the back.
    hbrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_snap),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_snap),
        .i_pop   (q_pop)
    );

    // Range checks and result delivery.
    hbrp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_valid     (q_valid),
        .i_q_data      (q_snap),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_outcome     (o_outcome),
        .o_range_start (o_range_start),
        .o_range_end   (o_range_end)
    );

endmodule

// File: dv/tb.sv
// Self-checking testbench for the HTTP byte-range header parser.
`timescale 1ns / 1ps

module tb;

    localparam logic [63:0] NUM_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          TAIL_CYCLES = 8;
    localparam int          CYCLE_LIMIT = 400000;

    // Shapes of a well-formed range value.
    typedef enum logic [1:0] {
        FORM_SPAN   = 2'd0,
        FORM_OPEN   = 2'd1,
        FORM_SUFFIX = 2'd2
    } t_form;

    // One expected parse answer.
    typedef struct {
        hbrp_pkg::t_outcome                oc;
        logic [hbrp_pkg::NUM_W-1:0]        first_byte;
        logic signed [hbrp_pkg::NUM_W:0]   last_byte;
    } t_range_ans;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_we    = 1'b0;
    logic [hbrp_pkg::NUM_W-1:0]       i_cfg_wdata = '0;
    logic                             i_valid     = 1'b0;
    logic                             i_command   = hbrp_pkg::CMD_CHAR;
    logic [7:0]                       i_char_code = 8'h00;
    logic                             i_stall     = 1'b0;
    logic                             o_stall;
    logic                             o_valid;
    logic [1:0]                       o_outcome;
    logic [hbrp_pkg::NUM_W-1:0]       o_range_start;
    logic signed [hbrp_pkg::NUM_W:0]  o_range_end;

    http_byte_range_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_char_code   (i_char_code),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_outcome     (o_outcome),
        .o_range_start (o_range_start),
        .o_range_end   (o_range_end)
    );

    // Answers still owed by the block, oldest first.
    t_range_ans pending_ranges[$];
    // Characters of the header value being built.
    logic [7:0] hdr_bytes[$];

    int  errors         = 0;
    int  reqs_sent      = 0;
    int  ranges_checked = 0;
    int  sizes_used     = 0;
    int  cycle_cnt      = 0;
    bit  send_gaps      = 1'b0;
    bit  sink_gaps      = 1'b0;
    int  stall_left     = 0;

    // Parser state mirrored by the predictor.
    string                      unit_text = "bytes=";
    logic [hbrp_pkg::NUM_W-1:0] size_bytes;
    hbrp_pkg::t_phase           phase;
    logic [2:0]                 prefix_cnt;
    logic                       got_char;
    logic                       shape_bad;
    logic                       blank_after;
    logic [hbrp_pkg::NUM_W-1:0] lo_num, hi_num;
    logic                       lo_present, hi_present;
    logic                       lo_bad, hi_bad;

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Global cycle limit.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Return the parse state to its idle value.
    function automatic void clear_parse_state();
        phase       = hbrp_pkg::PH_PREFIX;
        prefix_cnt  = 3'd0;
        got_char    = 1'b0;
        shape_bad   = 1'b0;
        blank_after = 1'b0;
        lo_num      = '0;
        hi_num      = '0;
        lo_present  = 1'b0;
        hi_present  = 1'b0;
        lo_bad      = 1'b0;
        hi_bad      = 1'b0;
    endfunction

    // Feed one character into the first or the second number.
    function automatic void take_part_char(input logic second, input logic [7:0] c);
        logic [hbrp_pkg::NUM_W-1:0] num;
        logic                       present;
        logic                       bad;
        logic [63:0]                digit;
        num     = second ? hi_num : lo_num;
        present = second ? hi_present : lo_present;
        bad     = second ? hi_bad : lo_bad;
        if (c == hbrp_pkg::CH_SPACE || c == hbrp_pkg::CH_TAB) begin
            if (present) blank_after = 1'b1;
        end else begin
            present = 1'b1;
            if (c >= hbrp_pkg::CH_ZERO && c <= hbrp_pkg::CH_NINE) begin
                digit = {56'd0, c - hbrp_pkg::CH_ZERO};
                if (blank_after) begin
                    bad = 1'b1;
                end else if (!bad) begin
                    if ({1'b0, num} > (NUM_MAX - digit) / 64'd10) begin
                        bad = 1'b1;
                    end else begin
                        num = hbrp_pkg::NUM_W'({1'b0, num} * 64'd10 + digit);
                    end
                end
            end else begin
                bad = 1'b1;
            end
        end
        if (second) begin
            hi_num = num; hi_present = present; hi_bad = bad;
        end else begin
            lo_num = num; lo_present = present; lo_bad = bad;
        end
    endfunction

    // Advance the parse by one header character.
    function automatic void take_char(input logic [7:0] c);
        logic [7:0] lc;
        got_char = 1'b1;
        if (!shape_bad) begin
            case (phase)
                hbrp_pkg::PH_PREFIX: begin
                    lc = (c >= hbrp_pkg::CH_UPPER_A && c <= hbrp_pkg::CH_UPPER_Z) ?
                         c + hbrp_pkg::CH_CASE_OFS : c;
                    if (prefix_cnt < 3'd6 && lc == unit_text[prefix_cnt]) begin
                        prefix_cnt++;
                        if (prefix_cnt == 3'd6) phase = hbrp_pkg::PH_FIRST;
                    end else begin
                        shape_bad = 1'b1;
                    end
                end
                hbrp_pkg::PH_FIRST: begin
                    if (c == hbrp_pkg::CH_DASH) begin
                        phase       = hbrp_pkg::PH_SECOND;
                        blank_after = 1'b0;
                    end else if (c == hbrp_pkg::CH_COMMA) begin
                        shape_bad = 1'b1;
                    end else begin
                        take_part_char(1'b0, c);
                    end
                end
                hbrp_pkg::PH_SECOND: begin
                    if (c == hbrp_pkg::CH_COMMA) phase = hbrp_pkg::PH_DONE;
                    else take_part_char(1'b1, c);
                end
                default: begin
                end
            endcase
        end
    endfunction

    // Work out the answer for the value parsed so far.
    function automatic t_range_ans close_range();
        t_range_ans  r;
        logic [63:0] fs, a, b, to;
        fs = {1'b0, size_bytes};
        a  = {1'b0, lo_num};
        b  = {1'b0, hi_num};
        r.oc         = hbrp_pkg::OUT_BAD;
        r.first_byte = '0;
        r.last_byte  = '0;
        if (!got_char) begin
            r.oc = hbrp_pkg::OUT_NONE;
        end else if (shape_bad || phase == hbrp_pkg::PH_PREFIX ||
                     phase == hbrp_pkg::PH_FIRST) begin
            r.oc = hbrp_pkg::OUT_BAD;
        end else if (!lo_present && !hi_present) begin
            r.oc = hbrp_pkg::OUT_BAD;
        end else if (!lo_present) begin
            // Suffix form: the last n bytes of the file.
            if (hi_bad) begin
                r.oc = hbrp_pkg::OUT_BAD;
            end else if (b == 64'd0) begin
                r.oc = hbrp_pkg::OUT_UNSAT;
            end else begin
                r.oc         = hbrp_pkg::OUT_OK;
                r.first_byte = (b >= fs) ? '0 : hbrp_pkg::NUM_W'(fs - b);
                r.last_byte  = fs - 64'd1;
            end
        end else if (lo_bad) begin
            r.oc = hbrp_pkg::OUT_BAD;
        end else if (a >= fs) begin
            r.oc = hbrp_pkg::OUT_UNSAT;
        end else if (hi_present && hi_bad) begin
            r.oc = hbrp_pkg::OUT_BAD;
        end else begin
            to = fs - 64'd1;
            if (hi_present && b < fs) to = b;
            if (to < a) begin
                r.oc = hbrp_pkg::OUT_UNSAT;
            end else begin
                r.oc         = hbrp_pkg::OUT_OK;
                r.first_byte = lo_num;
                r.last_byte  = to;
            end
        end
        return r;
    endfunction

    // Update the predictor for one accepted request.
    function automatic void note_request(input logic cmd, input logic [7:0] c);
        t_range_ans ans;
        if (cmd == hbrp_pkg::CMD_CHAR) begin
            take_char(c);
        end else begin
            ans = close_range();
            pending_ranges.insert(pending_ranges.size(), ans);
            clear_parse_state();
        end
    endfunction

    // Append one character to the value being built.
    function automatic void put_byte(input logic [7:0] b);
        hdr_bytes.insert(hdr_bytes.size(), b);
    endfunction

    // Send one request and wait until the block takes it.
    task automatic send_req(input logic cmd, input logic [7:0] c);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            i_valid     <= 1'b0;
            i_command   <= 1'($urandom);
            i_char_code <= 8'($urandom);
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_char_code <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        note_request(cmd, c);
        reqs_sent++;
    endtask

    // Drop valid and wait until every owed answer has arrived.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Write the file size while the block is idle.
    task automatic set_file_size(input logic [hbrp_pkg::NUM_W-1:0] size);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        size_bytes  = size;
        sizes_used++;
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) put_byte(s[k]);
    endtask

    // Send the built characters followed by the end request.
    task automatic send_header();
        foreach (hdr_bytes[k]) send_req(hbrp_pkg::CMD_CHAR, hdr_bytes[k]);
        send_req(hbrp_pkg::CMD_END, 8'($urandom));
        hdr_bytes.delete();
    endtask

    task automatic try_value(input string s);
        add_text(s);
        send_header();
    endtask

    // Zero or one blank, with equal chance.
    task automatic add_blanks();
        repeat ($urandom_range(0, 5) / 3) begin
            put_byte($urandom_range(0, 1) ? hbrp_pkg::CH_SPACE : hbrp_pkg::CH_TAB);
        end
    endtask

    // A decimal number chosen around the interesting points of the file size.
    task automatic add_number(input logic [hbrp_pkg::NUM_W-1:0] fs);
        logic [63:0] v;
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v = 64'd0;
            1:       v = $urandom_range(1, 20);
            2:       v = {1'b0, fs} - 64'd1;
            3:       v = {1'b0, fs};
            4:       v = {1'b0, fs} + 64'd1;
            5:       v = (fs == '0) ? 64'd0 : wide % {1'b0, fs};
            6:       v = NUM_MAX;
            7:       v = wide;
            8:       v = wide >> $urandom_range(1, 60);
            default: v = wide % ({1'b0, fs} + {2'b0, fs[hbrp_pkg::NUM_W-1:1]} + 64'd1);
        endcase
        if ($urandom_range(0, 7) == 0) add_text("00");
        add_text($sformatf("%0d", v));
    endtask

    // A well-formed range value with random case, blanks and tail.
    task automatic build_good(input logic [hbrp_pkg::NUM_W-1:0] fs);
        logic [7:0] ch;
        t_form      form;
        for (int k = 0; k < 6; k++) begin
            ch = unit_text[k];
            if (ch >= "a" && ch <= "z" && $urandom_range(0, 3) == 0) begin
                ch = ch - hbrp_pkg::CH_CASE_OFS;
            end
            put_byte(ch);
        end
        form = t_form'($urandom_range(0, 2));
        add_blanks();
        if (form != FORM_SUFFIX) add_number(fs);
        add_blanks();
        put_byte(hbrp_pkg::CH_DASH);
        add_blanks();
        if (form != FORM_OPEN) add_number(fs);
        add_blanks();
        case ($urandom_range(0, 5))
            0:       add_text(",");
            1:       add_text(", 1-2");
            2:       add_text(",x-,,");
            default: begin
            end
        endcase
    endtask

    // A character drawn mostly from the ones the parser cares about.
    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 7))
            0:       return hbrp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            1:       return hbrp_pkg::CH_DASH;
            2:       return hbrp_pkg::CH_COMMA;
            3:       return hbrp_pkg::CH_SPACE;
            4:       return hbrp_pkg::CH_TAB;
            5:       return unit_text[$urandom_range(0, 5)];
            6:       return hbrp_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
            default: return 8'($urandom);
        endcase
    endfunction

    // A broken or random value.
    task automatic build_noise(input logic [hbrp_pkg::NUM_W-1:0] fs);
        int pick;
        int idx;
        case ($urandom_range(0, 3))
            0: begin
                // Random text after a valid prefix.
                add_text("bytes=");
                repeat ($urandom_range(0, 10)) put_byte(noise_char());
            end
            1: begin
                // Random text from the very first character.
                repeat ($urandom_range(0, 8)) put_byte(noise_char());
            end
            2: begin
                // A good value with one character replaced.
                build_good(fs);
                idx = $urandom_range(0, hdr_bytes.size() - 1);
                hdr_bytes[idx] = noise_char();
            end
            default: begin
                // A good value cut short.
                build_good(fs);
                pick = $urandom_range(0, hdr_bytes.size() - 1);
                while (hdr_bytes.size() > pick) hdr_bytes.delete(hdr_bytes.size() - 1);
            end
        endcase
    endtask

    function automatic logic [hbrp_pkg::NUM_W-1:0] pick_size();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return hbrp_pkg::NUM_W'($urandom_range(1, 3));
            2:       return hbrp_pkg::NUM_W'($urandom_range(4, 2000));
            3:       return hbrp_pkg::NUM_W'(NUM_MAX);
            default: return hbrp_pkg::NUM_W'({$urandom, $urandom});
        endcase
    endfunction

    // Compare each answer with the oldest one owed, and drive the receiver stall.
    always @(posedge i_clk) begin : check_results
        t_range_ans want;
        if (i_rst_n && o_valid && !i_stall) begin
            ranges_checked++;
            if (pending_ranges.size() == 0) begin
                $display("%0t: answer with none owed: outcome %0d start %0d end %0d",
                         $time, o_outcome, o_range_start, o_range_end);
                errors++;
            end else begin
                want = pending_ranges.pop_front();
                if (o_outcome !== want.oc) begin
                    $display("%0t: outcome expected %0d, actual %0d", $time, want.oc, o_outcome);
                    errors++;
                end
                if (o_range_start !== want.first_byte) begin
                    $display("%0t: range_start expected %0d, actual %0d",
                             $time, want.first_byte, o_range_start);
                    errors++;
                end
                if (o_range_end !== want.last_byte) begin
                    $display("%0t: range_end expected %0d, actual %0d",
                             $time, want.last_byte, o_range_end);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Each form of range, the blank handling and the tail after a comma.
    task automatic test_range_forms();
        set_file_size(hbrp_pkg::NUM_W'(1000));
        try_value("bytes=0-499");
        try_value("bytes=500-");
        try_value("bytes=-200");
        try_value("ByTeS=10-20");
        try_value("");
        try_value("bytes=-0");
        try_value("bytes=-5000");
        try_value("bytes=1000-");
        try_value("bytes=999-");
        try_value("bytes=5-5000");
        try_value("bytes=50-10");
        try_value("bytes= 1 -\t2 ,junk");
        try_value("bytes=0-1,2-3");
        try_value("bytes=007-0010");
    endtask

    // Values the parser has to reject, and the start check that wins over them.
    task automatic test_malformed_values();
        try_value("bytes=1 2-3");
        try_value("bytes=5");
        try_value("bytes=5,6-7");
        try_value("bytes=-");
        try_value("byte");
        try_value("bytez=1-2");
        try_value("bytes=2000-x");
        try_value("bytes=9223372036854775808-");
        try_value("bytes=1-2x");
        try_value("bytes=abc-");
        try_value(" bytes=1-2");
        add_text("bytes=1");
        put_byte(8'hFF);
        add_text("-2");
        send_header();
        put_byte(8'h00);
        add_text("bytes=1-2");
        send_header();
    endtask

    // Empty file, one-byte file and the largest file.
    task automatic test_size_extremes();
        set_file_size('0);
        try_value("bytes=-5");
        try_value("bytes=0-");
        try_value("bytes=-0");
        set_file_size(hbrp_pkg::NUM_W'(1));
        try_value("bytes=0-0");
        try_value("bytes=-1");
        try_value("bytes=0-7");
        set_file_size(hbrp_pkg::NUM_W'(NUM_MAX));
        try_value("bytes=9223372036854775806-");
        try_value("bytes=-9223372036854775807");
        try_value("bytes=0-9223372036854775807");
        try_value("bytes=9223372036854775807-");
        try_value("bytes=-9223372036854775808");
    endtask

    // Random values over several file sizes, with sender gaps and receiver stalls switched on and off.
    task automatic test_random_values(input int n_phases, input int reqs_per_phase);
        int stop_at;
        for (int p = 0; p < n_phases; p++) begin
            set_file_size(p == 0 ? '0 :
                          (p == 1 ? hbrp_pkg::NUM_W'(NUM_MAX) : pick_size()));
            send_gaps = (p % 3 != 2);
            sink_gaps = (p % 3 != 1);
            stop_at   = reqs_sent + reqs_per_phase;
            while (reqs_sent < stop_at) begin
                if ($urandom_range(0, 4) == 0) build_noise(size_bytes);
                else build_good(size_bytes);
                send_header();
                // Now and then hold off until the block has drained.
                if ($urandom_range(0, 24) == 0) wait_idle();
            end
        end
    endtask

    // Back-to-back values with no gaps on either side.
    task automatic test_back_to_back(input int n_reqs);
        int stop_at;
        set_file_size(hbrp_pkg::NUM_W'($urandom_range(1, 500)));
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        stop_at   = reqs_sent + n_reqs;
        while (reqs_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) build_noise(size_bytes);
            else build_good(size_bytes);
            send_header();
        end
    endtask

    // Test sequence.
    initial begin
        size_bytes = '0;
        clear_parse_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_range_forms();
        test_malformed_values();
        test_size_extremes();
        test_random_values(6, 50);
        test_back_to_back(60);
        wait_idle();
        $display("Covered %0d requests and %0d checked answers over %0d file sizes,",
                 reqs_sent, ranges_checked, sizes_used);
        $display("with sender gaps and receiver stalls switched on and off; %0d mismatches.",
                 errors);
        if (errors == 0 && pending_ranges.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
